/* rtl/prta_pkg.sv */
// Package for the page region table allocator.
// Holds the request, response and table entry types and the shared codes.
// No dependencies.
package prta_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;

  localparam int PAGE_W  = 40;
  localparam int COUNT_W = 41;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_FREE  = 2'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_MARK  = 1'b1;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_MEMORY = 2'd1;
  localparam logic [1:0] ERR_NO_BOOT   = 2'd2;
  localparam logic [1:0] ERR_FULL      = 2'd3;

  typedef struct packed {
    logic [PAGE_W-1:0]  start;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } entry_t;

  typedef struct packed {
    logic               cmd;
    logic [PAGE_W-1:0]  start_page;
    logic [COUNT_W-1:0] page_count;
    logic [1:0]         region_status;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [1:0]        error_code;
    logic [PAGE_W-1:0] alloc_page;
  } rsp_t;

endpackage

/* rtl/page_region_table_allocator_top.sv */
// Top level of the page region table allocator.
// Depends on prta_pkg and prta_cell.
//
// Usage:
// Requests arrive on req (req_valid, req_stall); one response per request
// leaves on rsp (rsp_valid, rsp_stall). A transfer happens on a rising edge
// with valid high and stall low.
// The table is a ring of TABLE_ENTRIES slots that rotates one slot a cycle
// past a head cell during the scan and write laps. A request makes a scan lap
// over every slot, then a decision state, and, when the table changes, a write
// lap over every slot. A zero-length mark, or a mark that is not free before
// bootstrap, skips the laps and goes straight to the finish state.
// One request is in work at a time; req_stall is high while it runs.
// The response waits in an output register; while rsp_stall holds, the
// finished request waits there too and no new request is taken after it.
// Reset clears every slot to empty and clears the bootstrap flag.
module page_region_table_allocator_top #(
  parameter int TABLE_ENTRIES = prta_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  prta_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output prta_pkg::rsp_t rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_WRITE, S_FIN
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   idx;
  logic               cmd_r;
  logic [39:0]        sp_r;
  logic [40:0]        pc_r;
  logic [1:0]         st_r;
  logic [40:0]        end_r;
  logic               has_free;
  logic               found;
  logic [IDX_W-1:0]   fidx;
  prta_pkg::entry_t   fent;
  logic [41:0]        fend;
  logic [CNT_W-1:0]   empties;
  prta_pkg::rsp_t     res;
  logic               mod_en;
  prta_pkg::entry_t   mod_ent;
  prta_pkg::entry_t   pend_a;
  prta_pkg::entry_t   pend_b;
  logic               pend_a_v;
  logic               pend_b_v;

  prta_pkg::entry_t   q [TABLE_ENTRIES];
  prta_pkg::entry_t   head_next;
  logic               shift;

  // Ring of slots; the head slot feeds back into the tail.
  assign shift = (state == S_SCAN) || (state == S_WRITE);

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    prta_pkg::entry_t d;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign d = head_next;
    end else begin : g_mid
      assign d = q[i+1];
    end
    prta_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (q[i])
    );
  end

  // Clipping of the mark range to the end of page space.
  logic [40:0] avail;
  logic [40:0] pc_clip;
  logic [40:0] end_calc;
  assign avail    = 41'h100_0000_0000 - {1'b0, req.start_page};
  assign pc_clip  = (req.page_count > avail) ? avail : req.page_count;
  assign end_calc = {1'b0, req.start_page} + pc_clip;

  // Head slot match during the scan lap.
  logic [41:0] head_end;
  logic        head_match;
  assign head_end = {2'b0, q[0].start} + {1'b0, q[0].count};
  always_comb begin
    if (cmd_r == prta_pkg::CMD_ALLOC) begin
      head_match = (q[0].status == prta_pkg::ST_FREE) && (q[0].count >= pc_r);
    end else begin
      head_match = (q[0].status != prta_pkg::ST_EMPTY) && (sp_r >= q[0].start)
                   && ({1'b0, end_r} <= head_end);
    end
  end

  // Split arithmetic for the decision cycle.
  logic [39:0]    prefix;
  logic           pre_zero;
  logic [41:0]    suffix42;
  logic [40:0]    suffix;
  logic [1:0]     need;
  logic [CNT_W:0] have;
  logic [40:0]    remain;
  prta_pkg::entry_t range_ent;
  assign prefix    = sp_r - fent.start;
  assign pre_zero  = (prefix == '0);
  assign suffix42  = fend - {1'b0, end_r};
  assign suffix    = suffix42[40:0];
  assign need      = {1'b0, suffix != '0} + {1'b0, st_r != prta_pkg::ST_EMPTY};
  assign have      = {1'b0, empties} + {{CNT_W{1'b0}}, pre_zero};
  assign remain    = fent.count - pc_r;
  assign range_ent = '{start: sp_r, count: pc_r, status: st_r};

  // Write lap: apply the slot change, then fill empty slots in order.
  logic consume;
  always_comb begin
    head_next = q[0];
    consume   = 1'b0;
    if (state == S_WRITE) begin
      if (mod_en && (idx == fidx)) begin
        head_next = mod_ent;
      end
      if ((head_next.status == prta_pkg::ST_EMPTY) && pend_a_v) begin
        head_next = pend_a;
        consume   = 1'b1;
      end
    end
  end

  assign req_stall = (state != S_IDLE);

  // Sequencer with its registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      has_free  <= 1'b0;
      found     <= 1'b0;
      mod_en    <= 1'b0;
      pend_a_v  <= 1'b0;
      pend_b_v  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // The output register fills from the finish state and empties on a transfer.
      if ((state == S_FIN) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_r   <= req.cmd;
            sp_r    <= req.start_page;
            st_r    <= req.region_status;
            found   <= 1'b0;
            empties <= '0;
            idx     <= '0;
            if (req.cmd == prta_pkg::CMD_ALLOC) begin
              pc_r  <= req.page_count;
              state <= S_SCAN;
            end else if (req.page_count == '0) begin
              res   <= '{ok: 1'b1, error_code: prta_pkg::ERR_NONE, alloc_page: '0};
              state <= S_FIN;
            end else if (!has_free && (req.region_status != prta_pkg::ST_FREE)) begin
              res   <= '{ok: 1'b0, error_code: prta_pkg::ERR_NO_BOOT, alloc_page: '0};
              state <= S_FIN;
            end else begin
              has_free <= 1'b1;
              pc_r     <= pc_clip;
              end_r    <= end_calc;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!found && head_match) begin
            found <= 1'b1;
            fidx  <= idx;
            fent  <= q[0];
            fend  <= head_end;
          end
          if (q[0].status == prta_pkg::ST_EMPTY) begin
            empties <= empties + CNT_W'(1);
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_DECIDE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DECIDE: begin
          if (cmd_r == prta_pkg::CMD_ALLOC) begin
            pend_a_v <= 1'b0;
            pend_b_v <= 1'b0;
            if (found) begin
              res    <= '{ok: 1'b1, error_code: prta_pkg::ERR_NONE,
                          alloc_page: fent.start};
              mod_en <= 1'b1;
              if (remain == '0) begin
                mod_ent <= '0;
              end else begin
                mod_ent <= '{start: fent.start + pc_r[39:0], count: remain,
                             status: fent.status};
              end
              state <= S_WRITE;
            end else begin
              res    <= '{ok: 1'b0, error_code: prta_pkg::ERR_NO_MEMORY, alloc_page: '0};
              mod_en <= 1'b0;
              state  <= S_FIN;
            end
          end else if (found && (fent.status != st_r)) begin
            // Split of the containing region, if there is room for the pieces.
            if ({{(CNT_W-1){1'b0}}, need} > have) begin
              res      <= '{ok: 1'b0, error_code: prta_pkg::ERR_FULL, alloc_page: '0};
              mod_en   <= 1'b0;
              pend_a_v <= 1'b0;
              pend_b_v <= 1'b0;
              state    <= S_FIN;
            end else begin
              res    <= '{ok: 1'b1, error_code: prta_pkg::ERR_NONE, alloc_page: '0};
              mod_en <= 1'b1;
              if (pre_zero) begin
                mod_ent <= '0;
              end else begin
                mod_ent <= '{start: fent.start, count: {1'b0, prefix},
                             status: fent.status};
              end
              if (suffix != '0) begin
                pend_a   <= '{start: end_r[39:0], count: suffix, status: fent.status};
                pend_a_v <= 1'b1;
                pend_b   <= range_ent;
                pend_b_v <= (st_r != prta_pkg::ST_EMPTY);
              end else begin
                pend_a   <= range_ent;
                pend_a_v <= (st_r != prta_pkg::ST_EMPTY);
                pend_b_v <= 1'b0;
              end
              state <= S_WRITE;
            end
          end else if (!found && (st_r != prta_pkg::ST_EMPTY)) begin
            // A range that no region holds becomes a new entry if an empty slot is left.
            mod_en   <= 1'b0;
            pend_b_v <= 1'b0;
            if (empties == '0) begin
              res      <= '{ok: 1'b0, error_code: prta_pkg::ERR_FULL, alloc_page: '0};
              pend_a_v <= 1'b0;
              state    <= S_FIN;
            end else begin
              res      <= '{ok: 1'b1, error_code: prta_pkg::ERR_NONE, alloc_page: '0};
              pend_a   <= range_ent;
              pend_a_v <= 1'b1;
              state    <= S_WRITE;
            end
          end else begin
            res      <= '{ok: 1'b1, error_code: prta_pkg::ERR_NONE, alloc_page: '0};
            mod_en   <= 1'b0;
            pend_a_v <= 1'b0;
            pend_b_v <= 1'b0;
            state    <= S_FIN;
          end
        end
        S_WRITE: begin
          if (consume) begin
            pend_a   <= pend_b;
            pend_a_v <= pend_b_v;
            pend_b_v <= 1'b0;
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_FIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Every pending entry finds an empty slot by the end of the write lap.
  a_pending_placed: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && idx == LAST_IDX) |=> !pend_a_v)
    else $error("pending entry left unplaced after write lap");

  // The bootstrap flag is cleared only by reset.
  a_boot_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(has_free))
    else $error("bootstrap flag dropped");

  // The ring is at rest with the head at slot zero between requests.
  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (idx == '0))
    else $error("ring not aligned while idle");

  // A write lap only follows a decision.
  a_write_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_WRITE) |-> ($past(state) == S_DECIDE))
    else $error("write lap entered without decision");
`endif

endmodule

/* rtl/prta_cell.sv */
// One table slot of the region ring.
// Depends on prta_pkg for the entry type.
module prta_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  prta_pkg::entry_t d,
  output prta_pkg::entry_t q
);

  // The slot takes its neighbor's entry whenever the ring rotates.
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule
